// ===== design/lbrw_pkg.sv =====
// ----------------------------------------------------------------------------
// lbrw_pkg: shared constants
// Defaults and widths for the bounded range window block.
// ----------------------------------------------------------------------------
package lbrw_pkg;
  localparam int unsigned DefMaxLen      = 1024;
  localparam int unsigned DefSampleWidth = 32;
  localparam int unsigned RangeWidth     = 32;
  localparam int unsigned OutIdxWidth    = 11;
endpackage

// ===== design/lbrw_if.sv =====
// ----------------------------------------------------------------------------
// lbrw_if: valid/ready word channel
// Generic payload channel with source and sink modports.
// ----------------------------------------------------------------------------
interface lbrw_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/lbrw_cell.sv =====
// ----------------------------------------------------------------------------
// lbrw_cell: one queue cell
// Holds one (index, key) entry of a monotonic queue; shifts toward head.
// ----------------------------------------------------------------------------
module lbrw_cell #(
  parameter int unsigned IdxW = 10,
  parameter int unsigned KeyW = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop,       // shift: take neighbor's entry
  input  logic            load,      // write new entry
  input  logic            kill,      // drop entry (popped from tail)
  input  logic            up_vld,
  input  logic [IdxW-1:0] up_idx,
  input  logic [KeyW-1:0] up_key,
  input  logic [IdxW-1:0] new_idx,
  input  logic [KeyW-1:0] new_key,
  output logic            vld,
  output logic [IdxW-1:0] idx,
  output logic [KeyW-1:0] key
);
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= 1'b1;
      idx <= new_idx;
      key <= new_key;
    end else if (kill) begin
      vld <= 1'b0;
    end else if (pop) begin
      vld <= up_vld;
      idx <= up_idx;
      key <= up_key;
    end
  end
endmodule

// ===== design/lbrw_queue.sv =====
// ----------------------------------------------------------------------------
// lbrw_queue: monotonic queue as a row of cells
// Cell 0 is the head. Valid cells form a prefix. Each cell compares its own
// key with the incoming one, so a push drops every dominated tail entry and
// lands in the freed slot in the same cycle. One push or one head pop per
// cycle.
// ----------------------------------------------------------------------------
module lbrw_queue #(
  parameter int unsigned Depth   = 1024,
  parameter int unsigned IdxW    = 10,
  parameter int unsigned KeyW    = 32,
  parameter bit          KeepMax = 1'b1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  logic            pop_head,
  input  logic            push,
  input  logic [IdxW-1:0] new_idx,
  input  logic [KeyW-1:0] new_key,
  output logic [IdxW-1:0] head_idx,
  output logic [KeyW-1:0] head_key
);
  logic            vld [Depth+1];
  logic [IdxW-1:0] idx [Depth+1];
  logic [KeyW-1:0] key [Depth+1];
  logic            drop [Depth];
  logic            prev_kept [Depth];

  assign vld[Depth] = 1'b0;
  assign idx[Depth] = '0;
  assign key[Depth] = '0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    // entries beaten by the new key; monotonic order makes them a tail suffix
    assign drop[i] = vld[i] &&
                     (KeepMax ? (key[i] < new_key) : (key[i] > new_key));
    if (i == 0) begin : g_h
      assign prev_kept[i] = 1'b1;
    end else begin : g_n
      assign prev_kept[i] = vld[i-1] && !drop[i-1];
    end
    lbrw_cell #(.IdxW(IdxW), .KeyW(KeyW)) u_cell (
      .clk, .rst,
      .pop     (pop_head),
      .load    (push && (!vld[i] || drop[i]) && prev_kept[i]),
      .kill    (clear || (push && drop[i])),
      .up_vld  (vld[i+1]),
      .up_idx  (idx[i+1]),
      .up_key  (key[i+1]),
      .new_idx,
      .new_key,
      .vld     (vld[i]),
      .idx     (idx[i]),
      .key     (key[i])
    );
  end

  assign head_idx = idx[0];
  assign head_key = key[0];
endmodule

// ===== design/longest_bounded_range_window.sv =====
// ----------------------------------------------------------------------------
// longest_bounded_range_window: longest window with max - min <= limit
// Channel  | dir | payload
// in_ch    | in  | sample, last_sample
// out_ch   | out | best_start, best_end, overflow
// cfg_ch   | in  | range_limit
// A word is taken in the idle state, pushed into both cell rows in the push
// state, then the window shrinks one left-edge step per cycle; the last
// shrink cycle settles the best window and the done state finishes. The edge
// never passes the newest index, so it steps at most once per word on average.
// A word past MaxLen goes from idle straight to done.
// Reset clears all control state and the cell valid bits at once.
// A finished result holds in the output register; a later last word stalls
// in its final cycle until that register drains.
// ----------------------------------------------------------------------------
module longest_bounded_range_window #(
  parameter int unsigned MaxLen      = lbrw_pkg::DefMaxLen,
  parameter int unsigned SampleWidth = lbrw_pkg::DefSampleWidth
) (
  input logic clk,
  input logic rst,
  lbrw_if.sink   in_ch,
  lbrw_if.sink   cfg_ch,
  lbrw_if.source out_ch
);
  import lbrw_pkg::*;
  localparam int unsigned IdxW = $clog2(MaxLen);
  localparam int unsigned CntW = IdxW + 1;

  typedef enum logic [1:0] {S_IDLE, S_PUSH, S_SHRINK, S_DONE} state_t;
  state_t state;

  logic [RangeWidth-1:0]  range_limit;
  logic [SampleWidth-1:0] cur_key;
  logic                   cur_last;
  logic [CntW-1:0]        next_index;
  logic [IdxW-1:0]        window_left, best_left, best_right;
  logic                   overflow_seen, take;

  logic [SampleWidth-1:0] mx_hk, mn_hk;
  logic [IdxW-1:0]        mx_hi, mn_hi;
  logic                   q_push, hd_pop_mx, hd_pop_mn, clr, out_free;

  logic [IdxW-1:0] r_idx;
  logic [SampleWidth:0] diff;
  logic too_wide;

  assign r_idx = next_index[IdxW-1:0];
  // heads hold the window max and min, so the exact difference is never negative
  assign diff  = {1'b0, mx_hk} - {1'b0, mn_hk};
  assign too_wide = range_limit[RangeWidth-1] ||
                    ({{(64-SampleWidth-1){1'b0}}, diff} >
                     {32'b0, range_limit});

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state == S_IDLE);
  assign take = in_ch.valid && in_ch.ready;
  assign out_free = !out_ch.valid || out_ch.ready;

  // sequencer decodes
  always_comb begin
    hd_pop_mx = 1'b0; hd_pop_mn = 1'b0;
    case (state)
      S_SHRINK: begin
        if (window_left < r_idx && too_wide) begin
          // drop a head only when it sits at the edge being passed
          hd_pop_mx = (mx_hi == window_left);
          hd_pop_mn = (mn_hi == window_left);
        end
      end
      default: ;
    endcase
  end
  assign q_push = (state == S_PUSH);
  assign clr = (state == S_DONE) && cur_last && out_free;

  lbrw_queue #(.Depth(MaxLen), .IdxW(IdxW), .KeyW(SampleWidth), .KeepMax(1'b1)) u_max (
    .clk, .rst, .clear(clr), .pop_head(hd_pop_mx),
    .push(q_push), .new_idx(r_idx), .new_key(cur_key),
    .head_idx(mx_hi), .head_key(mx_hk));
  lbrw_queue #(.Depth(MaxLen), .IdxW(IdxW), .KeyW(SampleWidth), .KeepMax(1'b0)) u_min (
    .clk, .rst, .clear(clr), .pop_head(hd_pop_mn),
    .push(q_push), .new_idx(r_idx), .new_key(cur_key),
    .head_idx(mn_hi), .head_key(mn_hk));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; range_limit <= '0; next_index <= '0;
      window_left <= '0; best_left <= '0; best_right <= '0;
      overflow_seen <= 1'b0; out_ch.valid <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) range_limit <= cfg_ch.data;
      if (clr) out_ch.valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: if (take) begin
          // flip sign so keys order as unsigned
          cur_key  <= in_ch.data.sample[SampleWidth-1:0] ^
                      {1'b1, {(SampleWidth-1){1'b0}}};
          cur_last <= in_ch.data.last_sample;
          if (next_index < CntW'(MaxLen)) begin
            state <= S_PUSH;
          end else begin
            overflow_seen <= 1'b1;
            state <= S_DONE;
          end
        end
        S_PUSH: state <= S_SHRINK;
        S_SHRINK: begin
          if (window_left < r_idx && too_wide) begin
            window_left <= window_left + 1'b1;
          end else begin
            if (best_right - best_left < r_idx - window_left) begin
              best_right <= r_idx; best_left <= window_left;
            end
            next_index <= next_index + 1'b1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!cur_last) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_ch.data.best_start <= OutIdxWidth'({1'b0, best_left} + 1'b1);
            out_ch.data.best_end   <= OutIdxWidth'({1'b0, best_right} + 1'b1);
            out_ch.data.overflow   <= overflow_seen;
            next_index <= '0; window_left <= '0; best_left <= '0;
            best_right <= '0; overflow_seen <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ch.ready) else $error("word taken while busy");
  a_left_le_right: assert property (@(posedge clk) disable iff (rst)
    best_left <= best_right) else $error("best window inverted");
  a_out_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(clr)) else $error("result without last word");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.data)))
    else $error("stalled result word changed");
endmodule

// ===== bench/lbrw_tb_types.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbrw_tb_types: word layouts for the bench
// Payload types of the sample, result and limit channels.
// ----------------------------------------------------------------------------
package lbrw_tb_types;
  import lbrw_pkg::*;

  typedef struct packed {
    logic signed [DefSampleWidth-1:0] sample;
    logic                             last_sample;
  } sample_word_t;

  typedef struct packed {
    logic [OutIdxWidth-1:0] best_start;
    logic [OutIdxWidth-1:0] best_end;
    logic                   overflow;
  } window_word_t;

  typedef logic signed [RangeWidth-1:0] limit_word_t;
endpackage

// ===== bench/lbrw_window_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbrw_window_checker: window predictor and result compare
// Watches all channels, tracks the longest bounded window per sequence and
// compares each result word with the oldest predicted one.
// ----------------------------------------------------------------------------
module lbrw_window_checker #(
  parameter int unsigned MaxLen = lbrw_pkg::DefMaxLen
) (
  input  logic clk,
  input  logic rst,
  lbrw_if      in_ch,
  lbrw_if      cfg_ch,
  lbrw_if      out_ch,
  output int   fails,
  output int   pending,
  output int   results_seen
);
  import lbrw_pkg::*;
  import lbrw_tb_types::*;

  typedef struct {
    int     idx;
    longint val;
  } slot_t;

  slot_t        peak_q[$];
  slot_t        trough_q[$];
  window_word_t windows_due[$];
  int           left_edge, next_pos, best_l, best_r;
  bit           tail_dropped;
  limit_word_t  limit;

  function automatic bit too_wide(longint spread);
    if (limit < 0) return 1'b1;
    return spread > longint'(limit);
  endfunction

  task automatic clear_sequence();
    peak_q.delete();
    trough_q.delete();
    left_edge = 0;
    next_pos = 0;
    best_l = 0;
    best_r = 0;
    tail_dropped = 1'b0;
  endtask

  task automatic take_word(sample_word_t w);
    longint       v;
    int           r;
    window_word_t res;
    v = longint'(w.sample);
    r = next_pos;
    if (next_pos < MaxLen) begin
      while (peak_q.size() > 0 && peak_q[$].val < v) peak_q.delete(peak_q.size() - 1);
      peak_q.push_back('{r, v});
      while (trough_q.size() > 0 && trough_q[$].val > v)
        trough_q.delete(trough_q.size() - 1);
      trough_q.push_back('{r, v});
      // advance the left edge until the window fits the limit
      while (left_edge < r && too_wide(peak_q[0].val - trough_q[0].val)) begin
        if (peak_q.size() > 0 && peak_q[0].idx == left_edge) peak_q.delete(0);
        if (trough_q.size() > 0 && trough_q[0].idx == left_edge)
          trough_q.delete(0);
        left_edge++;
      end
      if (best_r - best_l < r - left_edge) begin
        best_r = r;
        best_l = left_edge;
      end
      next_pos = r + 1;
    end else begin
      tail_dropped = 1'b1;
    end
    if (w.last_sample) begin
      res.best_start = OutIdxWidth'(best_l + 1);
      res.best_end   = OutIdxWidth'(best_r + 1);
      res.overflow   = tail_dropped;
      windows_due.push_back(res);
      clear_sequence();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_sequence();
      windows_due.delete();
      limit = '0;
      fails = 0;
      results_seen = 0;
      pending = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) limit = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) take_word(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        window_word_t got, exp;
        got = out_ch.data;
        results_seen++;
        if (windows_due.size() == 0) begin
          $display("%0t: unexpected result start=%0d end=%0d overflow=%0b",
                   $time, got.best_start, got.best_end, got.overflow);
          fails++;
        end else begin
          exp = windows_due[0];
          windows_due.delete(0);
          if (got.best_start !== exp.best_start) begin
            $display("%0t: best_start expected %0d actual %0d",
                     $time, exp.best_start, got.best_start);
            fails++;
          end
          if (got.best_end !== exp.best_end) begin
            $display("%0t: best_end expected %0d actual %0d",
                     $time, exp.best_end, got.best_end);
            fails++;
          end
          if (got.overflow !== exp.overflow) begin
            $display("%0t: overflow expected %0b actual %0b",
                     $time, exp.overflow, got.overflow);
            fails++;
          end
        end
      end
      pending = windows_due.size();
    end
  end
endmodule

// ===== bench/tb_longest_bounded_range_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_longest_bounded_range_window: bench top for the bounded range window
// Feeds directed and random sample sequences under several range limits,
// with bursty input and a stalling result side; the checker judges results.
// ----------------------------------------------------------------------------
module tb_longest_bounded_range_window;
  import lbrw_pkg::*, lbrw_tb_types::*;

  localparam int CfgIndex   = 0;     // the one register: range_limit
  localparam int IdleLimit  = 20000; // cycles without any handshake
  localparam int LongHold   = 400;   // long result-side hold-off
  localparam int SettleWait = 50;    // trailing cycles once nothing is due

  logic clk = 1'b0;
  logic rst = 1'b1;

  lbrw_if #(.payload_t(sample_word_t)) in_ch ();
  lbrw_if #(.payload_t(limit_word_t))  cfg_ch ();
  lbrw_if #(.payload_t(window_word_t)) out_ch ();

  int fails, pending, results_seen;
  int words_sent, seqs_sent, limits_set;
  int burst_left;
  bit hold_req = 1'b0;
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  longest_bounded_range_window DUT (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .cfg_ch(cfg_ch),
    .out_ch(out_ch)
  );

  lbrw_window_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .cfg_ch      (cfg_ch),
    .out_ch      (out_ch),
    .fails       (fails),
    .pending     (pending),
    .results_seen(results_seen)
  );

  // Watchdog: end the run if no channel moves a word for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, IdleLimit);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: rotate through stall patterns, and hold off for a long
  // stretch on request so the block backs up into its input.
  initial begin
    int mode;
    int span;
    out_ch.ready = 1'b0;
    mode = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_req = 1'b0;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 200);
      end
      span--;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Offer one word and hold it until taken; ready is read at the falling
  // edge so the accept decision never races the block's own updates.
  task automatic push_sample(logic signed [31:0] s, bit last);
    bit taken;
    if (burst_left == 0) begin
      int gap;
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{sample: s, last_sample: last};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end
    words_sent++;
    if (last) seqs_sent++;
  endtask

  // Drop valid, let every due result drain, then write the limit.
  task automatic write_limit(limit_word_t v);
    bit taken;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ch.ready;
      @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
    limits_set++;
  endtask

  function automatic logic signed [31:0] pick_sample(int style, int base, int spread);
    if (style == 0) return $urandom();
    return base + $urandom_range(0, spread);
  endfunction

  // Random sequence: mostly short, values mostly clustered so limits matter.
  task automatic random_sequence(int len);
    int base, spread, style;
    base   = $urandom();
    spread = $urandom_range(0, 4) == 0 ? 1000000 : $urandom_range(0, 40);
    style  = ($urandom_range(0, 5) == 0) ? 0 : 1;
    for (int i = 0; i < len; i++)
      push_sample(pick_sample(style, base, spread), i == len - 1);
  endtask

  initial begin
    limit_word_t limits[6];
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    words_sent = 0;
    seqs_sent = 0;
    limits_set = 0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset limit of zero, a lone sample, equal runs.
    push_sample(32'sd7, 1'b1);
    push_sample(32'sd5, 1'b0);
    push_sample(32'sd5, 1'b0);
    push_sample(32'sd6, 1'b0);
    push_sample(32'sd6, 1'b1);
    // Extremes under the widest limit: full spread exceeds it.
    write_limit(32'sh7fffffff);
    push_sample(32'sh7fffffff, 1'b0);
    push_sample(32'sh80000000, 1'b0);
    push_sample(32'sh7fffffff, 1'b0);
    push_sample(32'sh00000000, 1'b1);
    // Negative limit: only single-sample windows qualify.
    write_limit(32'sh80000000);
    push_sample(32'sd1, 1'b0);
    push_sample(32'sd1, 1'b0);
    push_sample(32'sd1, 1'b1);
    write_limit(-32'sd1);
    push_sample(-32'sd3, 1'b0);
    push_sample(-32'sd3, 1'b1);
    // Small limit: an early tie for longest keeps the earlier window, then a longer one wins.
    write_limit(32'sd2);
    push_sample(32'sd0, 1'b0);
    push_sample(32'sd2, 1'b0);
    push_sample(32'sd9, 1'b0);
    push_sample(32'sd10, 1'b0);
    push_sample(32'sd11, 1'b1);

    // Too many samples: fill every slot, then one more that is dropped.
    write_limit(32'sd50);
    for (int i = 0; i < DefMaxLen + 1; i++)
      push_sample($urandom_range(0, 60), i == DefMaxLen);

    // Random phases under several limits, extremes among them.
    limits = '{32'sd0, 32'sh7fffffff, 32'sh80000000, 32'sd10, 32'sd25, 32'sd500000};
    for (int ph = 0; ph < 12; ph++) begin
      int stop_at;
      write_limit(ph < 6 ? limits[ph] : limit_word_t'($urandom_range(0, 60)));
      stop_at = words_sent + 8;
      if (ph == 4) begin
        // Long result hold-off while short sequences keep coming.
        hold_req = 1'b1;
        for (int k = 0; k < 10; k++) random_sequence($urandom_range(1, 4));
      end
      while (words_sent < stop_at)
        random_sequence($urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 12));
    end
    // Random limit bits from the full register range.
    write_limit($urandom());
    for (int k = 0; k < 5; k++) random_sequence($urandom_range(1, 10));

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);

    $display("Covered %0d sequences, %0d samples, %0d results, %0d limit writes.",
             seqs_sent, words_sent, results_seen, limits_set);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
